// ===== rtl/arc_pkg.sv =====
// arc_pkg: shared types and constants of the arp responder and cache
// used by arc_queue, arc_front, arc_back and arp_responder_cache; depends on nothing

package arc_pkg;

    localparam int TABLE_DEPTH_DEF   = 64;
    localparam int PENDING_DEPTH_DEF = 16;
    localparam int NIF_WIDTH         = 4;
    localparam int QUEUE_DEPTH       = 2;
    localparam int CFG_INDEX_W       = 8;
    localparam int CFG_DATA_W        = 48;

    localparam logic [CFG_INDEX_W-1:0] CFG_SELF_IP = CFG_INDEX_W'(0);

    localparam logic [15:0] PKT_OP_REQUEST = 16'd1;
    localparam logic [15:0] PKT_OP_REPLY   = 16'd2;
    localparam logic [1:0]  OUT_OP_REQUEST = 2'd1;
    localparam logic [1:0]  OUT_OP_REPLY   = 2'd2;
    localparam logic [47:0] MAC_BROADCAST  = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_NOT_US         = 3'd0,
        ST_REPLIED        = 3'd1,
        ST_REPLY_CONSUMED = 3'd2,
        ST_REQUEST_SENT   = 3'd3,
        ST_PENDING_HIT    = 3'd4,
        ST_PENDING_FULL   = 3'd5,
        ST_BAD_OPCODE     = 3'd6
    } arc_status_t;

    typedef enum logic [2:0] {
        K_NOT_US,
        K_REQUEST,
        K_REPLY,
        K_BAD_OP,
        K_RESOLVE
    } arc_kind_t;

    typedef struct packed {
        logic                 req_type;
        logic [15:0]          opcode;
        logic [31:0]          sender_ip;
        logic [47:0]          sender_mac;
        logic [31:0]          target_ip;
        logic [NIF_WIDTH-1:0] nif;
    } arc_in_t;

    typedef struct packed {
        logic                 send;
        logic [1:0]           out_opcode;
        logic [47:0]          eth_dst_mac;
        logic [47:0]          out_target_mac;
        logic [31:0]          out_target_ip;
        logic [NIF_WIDTH-1:0] out_nif;
        logic                 learned;
        logic                 table_full;
        arc_status_t          status;
    } arc_out_t;

    // classified word handed from front to back
    typedef struct packed {
        arc_kind_t            kind;
        logic [31:0]          sender_ip;
        logic [47:0]          sender_mac;
        logic [31:0]          target_ip;
        logic [NIF_WIDTH-1:0] nif;
    } arc_cmd_t;

endpackage

// ===== rtl/arc_ram.sv =====
// arc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module arc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/arc_queue.sv =====
// arc_queue: short fifo of classified words between front and back
// depends on arc_pkg

module arc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  arc_pkg::arc_cmd_t push_cmd,
    output logic              pop_valid,
    input  logic              pop_ready,
    output arc_pkg::arc_cmd_t pop_cmd
);

    localparam int DEPTH = arc_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    arc_pkg::arc_cmd_t entry_reg [DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[head_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
        tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                entry_reg[tail_reg] <= push_cmd;
                tail_reg            <= tail_next;
            end
            if (do_pop) begin
                head_reg <= head_next;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/arc_front.sv =====
// arc_front: configuration register and classification of incoming words
// depends on arc_pkg

module arc_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  arc_pkg::arc_in_t                   s_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [arc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [arc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                               push_valid,
    input  logic                               push_ready,
    output arc_pkg::arc_cmd_t                  push_cmd
);

    logic [31:0] self_ip_reg;

    assign cfg_ready  = 1'b1;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    // the own mac only feeds the sender field added by the framer, nothing kept here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            self_ip_reg <= '0;
        end else if (cfg_valid && cfg_index == arc_pkg::CFG_SELF_IP) begin
            self_ip_reg <= cfg_data[31:0];
        end
    end

    always_comb begin
        push_cmd.sender_ip  = s_data.sender_ip;
        push_cmd.sender_mac = s_data.sender_mac;
        push_cmd.target_ip  = s_data.target_ip;
        push_cmd.nif        = s_data.nif;
        if (s_data.req_type) begin
            push_cmd.kind = arc_pkg::K_RESOLVE;
        end else if (s_data.target_ip != self_ip_reg) begin
            push_cmd.kind = arc_pkg::K_NOT_US;
        end else if (s_data.opcode == arc_pkg::PKT_OP_REQUEST) begin
            push_cmd.kind = arc_pkg::K_REQUEST;
        end else if (s_data.opcode == arc_pkg::PKT_OP_REPLY) begin
            push_cmd.kind = arc_pkg::K_REPLY;
        end else begin
            push_cmd.kind = arc_pkg::K_BAD_OP;
        end
    end

endmodule

// ===== rtl/arc_back.sv =====
// arc_back: table and pending list engine with result register
// depends on arc_pkg and arc_ram

module arc_back #(
    parameter int TABLE_DEPTH   = arc_pkg::TABLE_DEPTH_DEF,
    parameter int PENDING_DEPTH = arc_pkg::PENDING_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  arc_pkg::arc_cmd_t q_cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output arc_pkg::arc_out_t m_data
);

    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int TCW = $clog2(TABLE_DEPTH + 1);
    localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PCW = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TSCAN,
        S_PSCAN
    } state_t;

    state_t              state_reg;
    arc_pkg::arc_cmd_t   cmd_reg;
    logic [31:0]         key_reg;
    logic [TCW-1:0]      t_count_reg;
    logic [TCW-1:0]      t_issue_reg;
    logic                t_chk_vld_reg;
    logic [PCW-1:0]      p_issue_reg;
    logic                p_chk_vld_reg;
    logic [PAW-1:0]      p_chk_idx_reg;
    logic                free_found_reg;
    logic [PAW-1:0]      free_idx_reg;
    logic [PENDING_DEPTH-1:0] pvalid_reg;
    logic                lrn_reg;
    logic                full_reg;
    logic                m_valid_reg;
    arc_pkg::arc_out_t   m_data_reg;

    logic [31:0]         tbl_rd;
    logic [31:0]         pnd_rd;
    logic                t_hit, t_miss, t_room, tbl_we;
    logic                p_hit, p_miss, p_issue_go, pnd_we;
    logic [PAW-1:0]      p_issue_idx;
    logic                done;
    arc_pkg::arc_out_t   res;

    arc_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_tbl_ip (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (t_count_reg[TAW-1:0]),
        .wdata (cmd_reg.sender_ip),
        .raddr (t_issue_reg[TAW-1:0]),
        .rdata (tbl_rd)
    );

    arc_ram #(.WIDTH(32), .DEPTH(PENDING_DEPTH)) u_pnd_ip (
        .aclk  (aclk),
        .we    (pnd_we),
        .waddr (free_idx_reg),
        .wdata (key_reg),
        .raddr (p_issue_idx),
        .rdata (pnd_rd)
    );

    assign q_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // read data is registered and belongs to the address issued in the cycle before
    assign t_hit  = t_chk_vld_reg && (tbl_rd == cmd_reg.sender_ip);
    assign t_miss = !t_chk_vld_reg && (t_issue_reg == t_count_reg);
    assign t_room = t_count_reg != TCW'(TABLE_DEPTH);
    assign tbl_we = (state_reg == S_TSCAN) && t_miss && t_room;

    assign p_issue_idx = p_issue_reg[PAW-1:0];
    assign p_issue_go  = p_issue_reg != PCW'(PENDING_DEPTH);
    assign p_hit  = p_chk_vld_reg && pvalid_reg[p_chk_idx_reg] && (pnd_rd == key_reg);
    assign p_miss = !p_chk_vld_reg && !p_issue_go;
    assign pnd_we = (state_reg == S_PSCAN) && (cmd_reg.kind == arc_pkg::K_RESOLVE)
                    && p_miss && free_found_reg;

    always_comb begin
        res        = '0;
        res.status = arc_pkg::ST_NOT_US;
        done       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (q_valid && q_ready) begin
                    case (q_cmd.kind)
                        arc_pkg::K_NOT_US: begin
                            done = 1'b1;
                        end
                        arc_pkg::K_BAD_OP: begin
                            done       = 1'b1;
                            res.status = arc_pkg::ST_BAD_OPCODE;
                        end
                        default: ;
                    endcase
                end
            end
            S_TSCAN: begin
                if ((t_hit || t_miss) && cmd_reg.kind == arc_pkg::K_REQUEST) begin
                    done               = 1'b1;
                    res.send           = 1'b1;
                    res.out_opcode     = arc_pkg::OUT_OP_REPLY;
                    res.eth_dst_mac    = cmd_reg.sender_mac;
                    res.out_target_mac = cmd_reg.sender_mac;
                    res.out_target_ip  = cmd_reg.sender_ip;
                    res.learned        = t_miss && t_room;
                    res.table_full     = t_miss && !t_room;
                    res.status         = arc_pkg::ST_REPLIED;
                end
            end
            S_PSCAN: begin
                if (cmd_reg.kind == arc_pkg::K_REPLY) begin
                    if (p_hit || p_miss) begin
                        done           = 1'b1;
                        res.learned    = lrn_reg;
                        res.table_full = full_reg;
                        res.status     = arc_pkg::ST_REPLY_CONSUMED;
                    end
                end else if (p_hit) begin
                    done       = 1'b1;
                    res.status = arc_pkg::ST_PENDING_HIT;
                end else if (p_miss) begin
                    done = 1'b1;
                    if (free_found_reg) begin
                        res.send          = 1'b1;
                        res.out_opcode    = arc_pkg::OUT_OP_REQUEST;
                        res.eth_dst_mac   = arc_pkg::MAC_BROADCAST;
                        res.out_target_ip = cmd_reg.target_ip;
                        res.out_nif       = cmd_reg.nif;
                        res.status        = arc_pkg::ST_REQUEST_SENT;
                    end else begin
                        res.status = arc_pkg::ST_PENDING_FULL;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            t_count_reg    <= '0;
            t_issue_reg    <= '0;
            t_chk_vld_reg  <= 1'b0;
            p_issue_reg    <= '0;
            p_chk_vld_reg  <= 1'b0;
            p_chk_idx_reg  <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            pvalid_reg     <= '0;
            lrn_reg        <= 1'b0;
            full_reg       <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (done) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= res;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid && q_ready) begin
                        cmd_reg        <= q_cmd;
                        key_reg        <= (q_cmd.kind == arc_pkg::K_RESOLVE) ?
                                          q_cmd.target_ip : q_cmd.sender_ip;
                        lrn_reg        <= 1'b0;
                        full_reg       <= 1'b0;
                        t_issue_reg    <= '0;
                        t_chk_vld_reg  <= 1'b0;
                        p_issue_reg    <= '0;
                        p_chk_vld_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        case (q_cmd.kind)
                            arc_pkg::K_REQUEST, arc_pkg::K_REPLY: state_reg <= S_TSCAN;
                            arc_pkg::K_RESOLVE:                   state_reg <= S_PSCAN;
                            default:                              state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_TSCAN: begin
                    if (t_hit || t_miss) begin
                        if (tbl_we) begin
                            t_count_reg <= t_count_reg + TCW'(1);
                        end
                        lrn_reg   <= t_miss && t_room;
                        full_reg  <= t_miss && !t_room;
                        state_reg <= (cmd_reg.kind == arc_pkg::K_REPLY) ? S_PSCAN : S_IDLE;
                    end else if (t_issue_reg != t_count_reg) begin
                        t_issue_reg   <= t_issue_reg + TCW'(1);
                        t_chk_vld_reg <= 1'b1;
                    end else begin
                        t_chk_vld_reg <= 1'b0;
                    end
                end
                S_PSCAN: begin
                    if (done) begin
                        state_reg <= S_IDLE;
                        if (pnd_we) begin
                            pvalid_reg[free_idx_reg] <= 1'b1;
                        end
                        if (cmd_reg.kind == arc_pkg::K_REPLY && p_hit) begin
                            pvalid_reg[p_chk_idx_reg] <= 1'b0;
                        end
                    end else begin
                        p_chk_vld_reg <= p_issue_go;
                        p_chk_idx_reg <= p_issue_idx;
                        if (p_issue_go) begin
                            p_issue_reg <= p_issue_reg + PCW'(1);
                            // slots are visited in order, so the first free one is the lowest
                            if (!pvalid_reg[p_issue_idx] && !free_found_reg) begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= p_issue_idx;
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/arp_responder_cache.sv =====
// Every input word yields exactly one result word. Words are classified on entry and held in a
// two-word queue, so input is taken while the engine is busy or a result waits. A packet not
// for us, or with a bad opcode, yields its result from the idle state without a scan. A request or reply
// addressed to us scans the learned-address table one entry per cycle through its single read
// port, stopping early on a hit. A reply then also scans the pending list, as does a local
// resolve request. Both stores need no clearing after reset; the table is read only below
// its fill count, and the pending list carries valid bits. The sender hardware address is
// inserted by the downstream framer.
// depends on arc_pkg, arc_front, arc_queue, arc_back, arc_ram

module arp_responder_cache #(
    parameter int TABLE_DEPTH   = arc_pkg::TABLE_DEPTH_DEF,
    parameter int PENDING_DEPTH = arc_pkg::PENDING_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  arc_pkg::arc_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output arc_pkg::arc_out_t               m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [arc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [arc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic              push_valid, push_ready;
    arc_pkg::arc_cmd_t push_cmd;
    logic              pop_valid, pop_ready;
    arc_pkg::arc_cmd_t pop_cmd;

    arc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    arc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    arc_back #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_cmd   (pop_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== tb/arp_responder_cache_tb.sv =====
// arp_responder_cache_tb: self-checking bench for the arp responder and cache
// directed words first, then random traffic over several address settings
// depends on arc_pkg and arp_responder_cache

module arp_responder_cache_tb;

    localparam int IDX_W  = arc_pkg::CFG_INDEX_W;
    localparam int NIF_W  = arc_pkg::NIF_WIDTH;
    localparam int PDEPTH = arc_pkg::PENDING_DEPTH_DEF;
    localparam logic [IDX_W-1:0] CFG_SELF_MAC = IDX_W'(1);
    localparam logic [31:0] DIR_IP = 32'h0A00_0001;
    localparam int POOL_SIZE = 24;
    localparam int RAND_PHASES = 5;
    localparam int PHASE_WORDS = 110;

    typedef struct {
        arc_pkg::arc_in_t  w;
        bit                fixed;
        arc_pkg::arc_out_t want;
    } plan_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    arc_pkg::arc_in_t              s_data;
    logic                          m_valid;
    logic                          m_ready;
    arc_pkg::arc_out_t             m_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [IDX_W-1:0]              cfg_index;
    logic [arc_pkg::CFG_DATA_W-1:0] cfg_data;

    // shadow of the block's state
    logic [31:0] own_ip;
    logic [31:0] known_ip[$];
    logic        wait_vld[PDEPTH];
    logic [31:0] wait_ip[PDEPTH];

    arc_pkg::arc_out_t outcome_q[$];
    logic [31:0]       res_pool[POOL_SIZE];
    plan_row_t         plan[$];

    int unsigned n_in;
    int unsigned n_out;
    int unsigned fails;
    int unsigned settings;
    int unsigned full_hits;
    int unsigned tally[0:7];

    arp_responder_cache dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d results outstanding", outcome_q.size());
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pending_slot(input logic [31:0] ip);
        for (int i = 0; i < PDEPTH; i++) begin
            if (wait_vld[i] && wait_ip[i] == ip) begin
                return i;
            end
        end
        return -1;
    endfunction

    // returns {table_full, learned}
    function automatic logic [1:0] learn_sender(input logic [31:0] ip);
        foreach (known_ip[i]) begin
            if (known_ip[i] == ip) begin
                return 2'b00;
            end
        end
        if (known_ip.size() >= arc_pkg::TABLE_DEPTH_DEF) begin
            return 2'b10;
        end
        known_ip.push_back(ip);
        return 2'b01;
    endfunction

    function automatic arc_pkg::arc_out_t predict_outcome(input arc_pkg::arc_in_t w);
        arc_pkg::arc_out_t r;
        int                slot;
        r = '0;
        if (!w.req_type) begin
            if (w.target_ip != own_ip) begin
                r.status = arc_pkg::ST_NOT_US;
            end else if (w.opcode == arc_pkg::PKT_OP_REQUEST) begin
                {r.table_full, r.learned} = learn_sender(w.sender_ip);
                r.send           = 1'b1;
                r.out_opcode     = arc_pkg::OUT_OP_REPLY;
                r.eth_dst_mac    = w.sender_mac;
                r.out_target_mac = w.sender_mac;
                r.out_target_ip  = w.sender_ip;
                r.status         = arc_pkg::ST_REPLIED;
            end else if (w.opcode == arc_pkg::PKT_OP_REPLY) begin
                {r.table_full, r.learned} = learn_sender(w.sender_ip);
                slot = pending_slot(w.sender_ip);
                if (slot >= 0) begin
                    wait_vld[slot] = 1'b0;
                end
                r.status = arc_pkg::ST_REPLY_CONSUMED;
            end else begin
                r.status = arc_pkg::ST_BAD_OPCODE;
            end
            return r;
        end
        if (pending_slot(w.target_ip) >= 0) begin
            r.status = arc_pkg::ST_PENDING_HIT;
            return r;
        end
        // lowest free slot wins
        for (int i = 0; i < PDEPTH; i++) begin
            if (!wait_vld[i]) begin
                wait_vld[i]     = 1'b1;
                wait_ip[i]      = w.target_ip;
                r.send          = 1'b1;
                r.out_opcode    = arc_pkg::OUT_OP_REQUEST;
                r.eth_dst_mac   = arc_pkg::MAC_BROADCAST;
                r.out_target_ip = w.target_ip;
                r.out_nif       = w.nif;
                r.status        = arc_pkg::ST_REQUEST_SENT;
                return r;
            end
        end
        r.status = arc_pkg::ST_PENDING_FULL;
        return r;
    endfunction

    function automatic arc_pkg::arc_in_t mk_in(input logic rt, input logic [15:0] op,
                                               input logic [31:0] sip, input logic [47:0] smac,
                                               input logic [31:0] tip,
                                               input logic [NIF_W-1:0] nif);
        arc_pkg::arc_in_t w;
        w.req_type   = rt;
        w.opcode     = op;
        w.sender_ip  = sip;
        w.sender_mac = smac;
        w.target_ip  = tip;
        w.nif        = nif;
        return w;
    endfunction

    function automatic arc_pkg::arc_out_t mk_out(input logic snd, input logic [1:0] op,
                                                 input logic [47:0] dst, input logic [47:0] tmac,
                                                 input logic [31:0] tip,
                                                 input logic [NIF_W-1:0] nif,
                                                 input logic lrn, input logic full,
                                                 input arc_pkg::arc_status_t st);
        arc_pkg::arc_out_t r;
        r.send           = snd;
        r.out_opcode     = op;
        r.eth_dst_mac    = dst;
        r.out_target_mac = tmac;
        r.out_target_ip  = tip;
        r.out_nif        = nif;
        r.learned        = lrn;
        r.table_full     = full;
        r.status         = st;
        return r;
    endfunction

    // mostly well-formed traffic to our address, some noise
    function automatic arc_pkg::arc_in_t random_word();
        arc_pkg::arc_in_t w;
        int unsigned      k;
        k = $urandom_range(0, 99);
        w = mk_in(1'b0, 16'($urandom), $urandom, {16'($urandom), 32'($urandom)}, own_ip,
                  NIF_W'($urandom));
        if (k < 35) begin
            w.req_type  = 1'b1;
            w.target_ip = (k < 4) ? $urandom : res_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (k < 60) begin
            w.opcode = arc_pkg::PKT_OP_REQUEST;
            if ($urandom_range(0, 9) < 3) begin
                w.sender_ip = res_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
        end else if (k < 80) begin
            w.opcode = arc_pkg::PKT_OP_REPLY;
            if ($urandom_range(0, 1) == 1) begin
                w.sender_ip = res_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
        end else if (k < 90) begin
            w.target_ip = $urandom;
        end
        return w;
    endfunction

    task automatic offer(input arc_pkg::arc_in_t w, input bit fixed,
                         input arc_pkg::arc_out_t want);
        int unsigned       gap;
        arc_pkg::arc_out_t exp_word;
        gap = (((n_in / 40) % 3) == 2) ? 0 : $urandom_range(0, 18);
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = w;
        do @(posedge aclk); while (!s_ready);
        exp_word = predict_outcome(w);
        if (fixed) begin
            exp_word = want;
        end
        outcome_q.push_back(exp_word);
        tally[exp_word.status]++;
        if (exp_word.table_full) begin
            full_hits++;
        end
        n_in++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [47:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == arc_pkg::CFG_SELF_IP) begin
            own_ip = val[31:0];
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (outcome_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic check_outcome(input arc_pkg::arc_out_t got);
        arc_pkg::arc_out_t want;
        if (outcome_q.size() == 0) begin
            fails++;
            if (fails <= 10) begin
                $display("result %0d arrived with nothing outstanding", n_out);
            end
            n_out++;
            return;
        end
        want = outcome_q.pop_front();
        if (got.send !== want.send || got.out_opcode !== want.out_opcode
            || got.eth_dst_mac !== want.eth_dst_mac
            || got.out_target_mac !== want.out_target_mac
            || got.out_target_ip !== want.out_target_ip || got.out_nif !== want.out_nif
            || got.learned !== want.learned || got.table_full !== want.table_full
            || got.status !== want.status) begin
            fails++;
            if (fails <= 10) begin
                $display("mismatch at result %0d", n_out);
                $display("  exp send=%0d op=%0d dst=%h tmac=%h ",
                         want.send, want.out_opcode, want.eth_dst_mac, want.out_target_mac,
                         "tip=%h nif=%h lrn=%0d full=%0d st=%0d",
                         want.out_target_ip, want.out_nif, want.learned, want.table_full,
                         want.status);
                $display("  got send=%0d op=%0d dst=%h tmac=%h ",
                         got.send, got.out_opcode, got.eth_dst_mac, got.out_target_mac,
                         "tip=%h nif=%h lrn=%0d full=%0d st=%0d",
                         got.out_target_ip, got.out_nif, got.learned, got.table_full,
                         got.status);
            end
        end
        n_out++;
    endtask

    // result side: random stalls, bursts of full rate, and two long hold-offs
    initial begin : sink
        int unsigned gap;
        int unsigned hold;
        m_ready = 1'b0;
        gap     = 0;
        hold    = 0;
        forever begin
            @(negedge aclk);
            if (hold != 0) begin
                m_ready = 1'b0;
                hold    = hold - 1;
            end else if (gap != 0) begin
                m_ready = 1'b0;
                gap     = gap - 1;
            end else begin
                m_ready = 1'b1;
            end
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_outcome(m_data);
                gap = (((n_out / 48) % 3) == 1) ? 0 : $urandom_range(0, 18);
                if (n_out == 120 || n_out == 400) begin
                    hold = 300;
                end
            end
        end
    end

    initial begin : stimulus
        logic [31:0] sip;
        logic [47:0] smac;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        aresetn   = 1'b0;
        own_ip    = '0;
        n_in      = 0;
        n_out     = 0;
        fails     = 0;
        settings  = 0;
        full_hits = 0;
        foreach (tally[i]) tally[i] = 0;
        foreach (wait_vld[i]) wait_vld[i] = 1'b0;
        foreach (res_pool[i]) res_pool[i] = $urandom;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_reg(arc_pkg::CFG_SELF_IP, {16'($urandom), DIR_IP});
        write_reg(CFG_SELF_MAC, {16'($urandom), 32'($urandom)});
        settings++;

        sip  = 32'h5555_AAAA;
        smac = {16'($urandom), 32'($urandom)};
        plan.push_back('{mk_in(1'b0, arc_pkg::PKT_OP_REQUEST, sip, smac, DIR_IP ^ 32'h1,
                               4'h3), 1'b1,
                         mk_out(1'b0, 2'd0, '0, '0, '0, '0, 1'b0, 1'b0,
                                arc_pkg::ST_NOT_US)});
        plan.push_back('{mk_in(1'b0, 16'h0000, sip, smac, DIR_IP, 4'h0), 1'b1,
                         mk_out(1'b0, 2'd0, '0, '0, '0, '0, 1'b0, 1'b0,
                                arc_pkg::ST_BAD_OPCODE)});
        plan.push_back('{mk_in(1'b0, 16'hFFFF, sip, smac, DIR_IP, 4'hF), 1'b1,
                         mk_out(1'b0, 2'd0, '0, '0, '0, '0, 1'b0, 1'b0,
                                arc_pkg::ST_BAD_OPCODE)});
        // first sender after reset is always learned
        plan.push_back('{mk_in(1'b0, arc_pkg::PKT_OP_REQUEST, '1, arc_pkg::MAC_BROADCAST,
                               DIR_IP, 4'hF), 1'b1,
                         mk_out(1'b1, arc_pkg::OUT_OP_REPLY, arc_pkg::MAC_BROADCAST,
                                arc_pkg::MAC_BROADCAST, '1, '0, 1'b1, 1'b0,
                                arc_pkg::ST_REPLIED)});
        plan.push_back('{mk_in(1'b0, arc_pkg::PKT_OP_REQUEST, '1, '0, DIR_IP, 4'h5), 1'b0,
                         '0});
        plan.push_back('{mk_in(1'b0, arc_pkg::PKT_OP_REQUEST, '0, '0, DIR_IP, 4'h0), 1'b0,
                         '0});
        plan.push_back('{mk_in(1'b1, 16'h0000, '0, '0, res_pool[0], 4'hF), 1'b1,
                         mk_out(1'b1, arc_pkg::OUT_OP_REQUEST, arc_pkg::MAC_BROADCAST, '0,
                                res_pool[0], 4'hF, 1'b0, 1'b0, arc_pkg::ST_REQUEST_SENT)});
        plan.push_back('{mk_in(1'b1, 16'hFFFF, '1, arc_pkg::MAC_BROADCAST, res_pool[0], 4'h0),
                         1'b1,
                         mk_out(1'b0, 2'd0, '0, '0, '0, '0, 1'b0, 1'b0,
                                arc_pkg::ST_PENDING_HIT)});
        // fill the pending list, overflow it, free one slot and reuse it
        for (int i = 1; i <= PDEPTH; i++) begin
            plan.push_back('{mk_in(1'b1, 16'($urandom), $urandom, smac, res_pool[i],
                                   NIF_W'(i)), 1'b0, '0});
        end
        plan.push_back('{mk_in(1'b0, arc_pkg::PKT_OP_REPLY, res_pool[3], smac, DIR_IP, 4'h2),
                         1'b0, '0});
        plan.push_back('{mk_in(1'b1, arc_pkg::PKT_OP_REQUEST, '0, '0, res_pool[16], 4'h9),
                         1'b0, '0});
        plan.push_back('{mk_in(1'b0, arc_pkg::PKT_OP_REPLY, sip, smac, DIR_IP, 4'h0), 1'b0,
                         '0});

        foreach (plan[i]) offer(plan[i].w, plan[i].fixed, plan[i].want);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(arc_pkg::CFG_SELF_IP, 48'h0);
                    write_reg(CFG_SELF_MAC, 48'h0);
                end
                1: begin
                    write_reg(arc_pkg::CFG_SELF_IP, {16'($urandom), 32'hFFFF_FFFF});
                    write_reg(CFG_SELF_MAC, arc_pkg::MAC_BROADCAST);
                end
                default: begin
                    write_reg(arc_pkg::CFG_SELF_IP, {16'($urandom), 32'($urandom)});
                    write_reg(CFG_SELF_MAC, {16'($urandom), 32'($urandom)});
                end
            endcase
            settings++;
            repeat (PHASE_WORDS) offer(random_word(), 1'b0, '0);
        end
        drain();
        repeat (40) @(posedge aclk);

        $display("%0d words, %0d results, %0d address settings, %0d senders learned",
                 n_in, n_out, settings, known_ip.size());
        $display("replied %0d, consumed %0d, sent %0d, pending hit %0d, ",
                 tally[arc_pkg::ST_REPLIED], tally[arc_pkg::ST_REPLY_CONSUMED],
                 tally[arc_pkg::ST_REQUEST_SENT], tally[arc_pkg::ST_PENDING_HIT],
                 "pending full %0d, bad op %0d, not ours %0d, table overflow %0d",
                 tally[arc_pkg::ST_PENDING_FULL], tally[arc_pkg::ST_BAD_OPCODE],
                 tally[arc_pkg::ST_NOT_US], full_hits);
        if (fails == 0 && outcome_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
